@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file aes_checker.sv.
// No dependencies; clock i_clk and reset i_rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/aes_pkg.sv @@
// AES-128 package: S-box tables, round constants and round functions.
// No dependencies; used by aes128_block_cipher_top.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int BlkW      = 128;
    localparam int AddrW     = 4;

    typedef logic [BlkW-1:0] t_block;
    typedef logic [7:0]      t_byte;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Round constants for key rounds 1..10 (entry 0 unused).
    localparam t_byte RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte n of a block sits at bits [127-8n -: 8].
    function automatic t_byte get_b(input t_block s, input int n);
        get_b = s[BlkW-1-8*n -: 8];
    endfunction

    function automatic t_byte xt(input t_byte a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block sub_bytes(input t_block s, input logic inv);
        t_block o;
        for (int n = 0; n < 16; n++) begin
            o[BlkW-1-8*n -: 8] = inv ? INV_SBOX[get_b(s, n)] : SBOX[get_b(s, n)];
        end
        sub_bytes = o;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic inv);
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[BlkW-1-8*(4*c+r) -: 8] = inv ? get_b(s, ((c - r + 4) % 4) * 4 + r)
                                               : get_b(s, ((c + r) % 4) * 4 + r);
            end
        end
        shift_rows = o;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic inv);
        t_block o;
        t_byte  a [4];
        t_byte  x2 [4];
        t_byte  x4 [4];
        t_byte  x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_b(s, 4*c + r);
                x2[r] = xt(a[r]);
                x4[r] = xt(x2[r]);
                x8[r] = xt(x4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    // 14, 11, 13, 9
                    o[BlkW-1-8*(4*c+r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                        (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                        (x8[(r+3)%4] ^ a[(r+3)%4]);
                end else begin
                    o[BlkW-1-8*(4*c+r) -: 8] =
                        x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
                end
            end
        end
        mix_columns = o;
    endfunction

    // One key-schedule round: previous round key to next.
    function automatic t_block key_next(input t_block k, input t_byte rc);
        logic [31:0] w [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) begin
            w[i] = k[BlkW-1-32*i -: 32];
        end
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        key_next = {w[0], w[1], w[2], w[3]};
    endfunction

endpackage

@@ rtl/aes128_block_cipher_top.sv @@
// AES-128 encrypt/decrypt engine, one round per pipeline stage.
// Depends on aes_pkg.
//
// Usage:
//  - Input channel (i_valid/o_ready): one transaction is one 128-bit block
//    (i_block_high, i_block_low) and i_command (0 encrypt, 1 decrypt).
//  - Output channel (o_valid/i_ready): one transaction per input, carrying
//    o_out_high/o_out_low, in input order.
//  - Key: written over the APB port, key_high at 0x0, key_low at 0x8
//    (paddr[3] selects). After each key write the round-key expander runs
//    through all round keys, one round key per cycle; o_ready is low meanwhile.
//  - Pipeline: an initial key add stage, loaded at the accepting edge, plus
//    ten round stages; the last one drives o_valid. Throughput: one block per
//    cycle, set by the one-round-per-stage pipeline, while the output is not stalled and no key expansion runs.
//  - Reset (synchronous, i_rst_n low): pipeline empties, key clears to zero
//    and the expander runs a full pass before the first block is taken.
//  - Stall: each stage holds when its successor is full and blocked, so
//    bubbles close up and nothing is dropped or repeated.
module aes128_block_cipher_top
    import aes_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [63:0]      i_block_high,
    input  logic [63:0]      i_block_low,
    // output channel
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_out_high,
    output logic [63:0]      o_out_low,
    // APB config port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int LastRound = NumRounds;

    // key registers
    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        w_cfg_wr;

    // round key expander
    t_block      r_rk [NumRounds+1];
    t_block      r_kprev;
    t_block      n_key;
    logic        r_busy;
    logic [3:0]  r_kidx;

    // pipeline
    t_block      r_st  [NumRounds+1];
    logic        r_cmd [NumRounds+1];
    logic        r_v   [NumRounds+1];
    t_block      n_st  [NumRounds+1];
    logic        w_adv [NumRounds+1];

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = paddr[3] ? r_key_low : r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[3]) begin
                r_key_low <= pwdata;
            end else begin
                r_key_high <= pwdata;
            end
        end
    end

    // ---------------- key expansion ----------------
    // Index 0 loads the raw key; index k derives round key k from k-1.
    always_comb begin
        if (r_kidx == 4'd0) begin
            n_key = {r_key_high, r_key_low};
        end else begin
            n_key = key_next(r_kprev, RCON[r_kidx]);
        end
    end

    // Index parks on the last round once the pass is done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_kidx <= '0;
        end else if (w_cfg_wr) begin
            r_busy <= 1'b1;
            r_kidx <= '0;
        end else if (r_busy) begin
            if (r_kidx == 4'(LastRound)) begin
                r_busy <= 1'b0;
            end else begin
                r_kidx <= r_kidx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_kprev <= n_key;
            for (int i = 0; i <= NumRounds; i++) begin
                if (r_kidx == 4'(i)) begin
                    r_rk[i] <= n_key;
                end
            end
        end
    end

    // ---------------- handshake ----------------
    // A stage may load when it is empty or its content moves on.
    always_comb begin
        w_adv[LastRound] = !r_v[LastRound] || i_ready;
        for (int j = LastRound - 1; j >= 0; j--) begin
            w_adv[j] = !r_v[j] || w_adv[j+1];
        end
    end

    assign o_ready = !r_busy && w_adv[0];

    // ---------------- round datapath ----------------
    always_comb begin
        // stage 0: initial key add (last round key when decrypting)
        n_st[0] = {i_block_high, i_block_low} ^ (i_command ? r_rk[NumRounds] : r_rk[0]);
        for (int j = 1; j <= NumRounds; j++) begin
            if (r_cmd[j-1]) begin
                n_st[j] = sub_bytes(shift_rows(r_st[j-1], 1'b1), 1'b1) ^ r_rk[NumRounds-j];
                if (j != NumRounds) begin
                    n_st[j] = mix_columns(n_st[j], 1'b1);
                end
            end else begin
                n_st[j] = shift_rows(sub_bytes(r_st[j-1], 1'b0), 1'b0);
                if (j != NumRounds) begin
                    n_st[j] = mix_columns(n_st[j], 1'b0);
                end
                n_st[j] = n_st[j] ^ r_rk[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NumRounds; j++) begin
                r_v[j] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid && !r_busy;
            end
            for (int j = 1; j <= NumRounds; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_st[0]  <= n_st[0];
            r_cmd[0] <= i_command;
        end
        for (int j = 1; j <= NumRounds; j++) begin
            if (w_adv[j]) begin
                r_st[j]  <= n_st[j];
                r_cmd[j] <= r_cmd[j-1];
            end
        end
    end

    assign o_valid    = r_v[LastRound];
    assign o_out_high = r_st[LastRound][127:64];
    assign o_out_low  = r_st[LastRound][63:0];

endmodule

@@ rtl/aes_checker.sv @@
// Port-level checker for aes128_block_cipher_top, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module aes_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [63:0]      o_out_high,
    input logic [63:0]      o_out_low,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic             pready
);

    // stalled result holds
    `CHK_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_out_high) && $stable(o_out_low), "result changed while stalled")
    // no result right after reset
    `CHK_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "result valid after reset")
    // a key write restarts expansion, blocking input
    `CHK_ASSERT(a_key_block, psel && penable && pwrite |=> !o_ready, "input taken during key expansion")
    // a result only leaves when taken
    `CHK_ASSERT(a_out_leave, $fell(o_valid) |-> $past(i_ready), "result dropped without handshake")
    // config port never waits
    `CHK_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind aes128_block_cipher_top aes_checker u_aes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_high (o_out_high),
    .o_out_low  (o_out_low),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready)
);
